@@ rtl/core/tcd_pkg.sv @@
// Shared types and constants for the telecine cadence detector.
// No dependencies; every other file of the block imports this package.
package tcd_pkg;

    localparam int SUM_W_DEFAULT   = 48;
    localparam int SCORE_W_DEFAULT = 24;

    localparam int PIX_W   = 8;
    localparam int DIFF_W  = 11;
    localparam int SQ_W    = 18;
    localparam int TERM_W  = 20;
    localparam int IN_W    = 6 * PIX_W;

    localparam int SLOTS       = 10;
    localparam int SLOT_W      = 4;
    localparam int CYCLE       = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W = 3;
    localparam logic REG_LOCK   = 1'b0;
    localparam logic REG_DECOMB = 1'b1;

    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        logic                     field;
        logic                     last;
    } queue_entry_t;

endpackage

@@ rtl/core/telecine_cadence_detector.sv @@
// Top level of the telecine cadence detector: register port, front end, queue, back end.
// Depends on tcd_pkg, tcd_front, tcd_queue and tcd_back.
//
// Channel   Direction  Payload
// s_axis    in         tdata: cur/prev above, middle, below; tuser: field; tlast: frame end
// m_axis    out        tdata: applied cadence, new decision, best score
// apb       in/out     lock_enable at 0x0, decomb_mode at 0x4
//
// The front end takes one transaction per cycle while the four-entry queue has room.
// Outside lock mode, a frame end holds the back end while the shared one-bit-per-cycle square
// root runs once per field; decision frames also hold it through the decide and emit states.
// Reset is asynchronous and active low; it clears the history and the cadence state.
// A result waits in the output register while the back end keeps draining the queue.
module telecine_cadence_detector
    import tcd_pkg::*;
#(
    parameter int SUM_WIDTH   = SUM_W_DEFAULT,
    parameter int SCORE_WIDTH = SCORE_W_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cur_above, cur_middle, cur_below, prev_above, prev_middle, prev_below
    input  logic [IN_W-1:0]                        s_axis_tdata,
    // field_select
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // drop_mode, offset_first, offset_second, invert_polarity, next_drop_mode,
    // next_offset, next_polarity, win_score
    output logic [((SCORE_WIDTH + 22) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ADDR_W-1:0]                      paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int OUT_W = ((SCORE_WIDTH + 22) / 8) * 8;

    logic                   lock_reg, decomb_reg;
    logic                   cfg_write;
    logic                   q_push, q_pop, q_full, q_empty;
    queue_entry_t           push_entry, pop_entry;
    logic [SCORE_WIDTH+14:0] res_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DECOMB) ? {31'b0, decomb_reg} : {31'b0, lock_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg   <= 1'b0;
            decomb_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_LOCK:   lock_reg   <= pwdata[0];
                REG_DECOMB: decomb_reg <= pwdata[0];
                default:    lock_reg   <= lock_reg;
            endcase
        end
    end

    tcd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    tcd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    tcd_back #(.SUM_WIDTH(SUM_WIDTH), .SCORE_WIDTH(SCORE_WIDTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lock_enable (lock_reg),
        .decomb_mode (decomb_reg),
        .q_empty     (q_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (res_data)
    );

    assign m_axis_tdata = OUT_W'(res_data);

endmodule

@@ rtl/core/tcd_front.sv @@
// Front end: takes pixel transactions and forms the combing-improvement term.
// Depends on tcd_pkg; feeds tcd_queue.
module tcd_front
    import tcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tuser,
    input  logic              s_axis_tlast,
    input  logic              q_full,
    output logic              q_push,
    output queue_entry_t      q_entry
);

    logic [PIX_W-1:0]           a, b, c, d, e, f;
    logic signed [DIFF_W-1:0]   dc, dp, dm;
    logic signed [2*DIFF_W-1:0] pc, pp, pm;
    logic [SQ_W-1:0]            sq_cur_reg, sq_prev_reg, sq_mix_reg;
    logic                       field_reg, last_reg;
    logic                       stage_valid_reg;
    logic                       accept;

    assign a = s_axis_tdata[7:0];
    assign b = s_axis_tdata[15:8];
    assign c = s_axis_tdata[23:16];
    assign d = s_axis_tdata[31:24];
    assign e = s_axis_tdata[39:32];
    assign f = s_axis_tdata[47:40];

    assign dc = $signed({3'b000, a}) + $signed({3'b000, c}) - $signed({2'b00, b, 1'b0});
    assign dp = $signed({3'b000, d}) + $signed({3'b000, f}) - $signed({2'b00, e, 1'b0});
    assign dm = $signed({3'b000, a}) + $signed({3'b000, c}) - $signed({2'b00, e, 1'b0});

    assign pc = (2*DIFF_W)'(dc) * (2*DIFF_W)'(dc);
    assign pp = (2*DIFF_W)'(dp) * (2*DIFF_W)'(dp);
    assign pm = (2*DIFF_W)'(dm) * (2*DIFF_W)'(dm);

    assign s_axis_tready = !stage_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_push        = stage_valid_reg && !q_full;

    assign q_entry.term  = $signed({2'b00, sq_cur_reg}) + $signed({2'b00, sq_prev_reg})
                         - $signed({2'b00, sq_mix_reg});
    assign q_entry.field = field_reg;
    assign q_entry.last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_cur_reg  <= pc[SQ_W-1:0];
            sq_prev_reg <= pp[SQ_W-1:0];
            sq_mix_reg  <= pm[SQ_W-1:0];
            field_reg   <= s_axis_tuser;
            last_reg    <= s_axis_tlast;
        end
    end

endmodule

@@ rtl/core/tcd_queue.sv @@
// Short queue of classified terms between the front end and the back end.
// Depends on tcd_pkg.
module tcd_queue
    import tcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output queue_entry_t pop_entry,
    output logic         empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/tcd_sqrt.sv @@
// Iterative floor square root, one result bit per cycle.
// Depends on tcd_pkg; used by tcd_back.
module tcd_sqrt
    import tcd_pkg::*;
#(
    parameter int ROOT_W = SUM_W_DEFAULT / 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [ROOT_W+1:0]   rem_shift, trial;
    logic                take;

    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);
    assign done      = done_reg;
    assign root      = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

endmodule

@@ rtl/core/tcd_back.sv @@
// Back end: field accumulation, frame-end scoring, history and cadence decision.
// Depends on tcd_pkg and tcd_sqrt; drains tcd_queue and drives the result register.
module tcd_back
    import tcd_pkg::*;
#(
    parameter int SUM_WIDTH   = SUM_W_DEFAULT,
    parameter int SCORE_WIDTH = SCORE_W_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    lock_enable,
    input  logic                    decomb_mode,
    input  logic                    q_empty,
    input  queue_entry_t            q_entry,
    output logic                    q_pop,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [SCORE_WIDTH+14:0] res_data
);

    localparam int ROOT_W = (SUM_WIDTH + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int WIDE_W = (ROOT_W > SCORE_WIDTH) ? ROOT_W : SCORE_WIDTH;
    localparam int RES_W  = SCORE_WIDTH + 15;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_R0_GO   = 3'd1;
    localparam logic [2:0] ST_R0_WAIT = 3'd2;
    localparam logic [2:0] ST_R1_GO   = 3'd3;
    localparam logic [2:0] ST_R1_WAIT = 3'd4;
    localparam logic [2:0] ST_DECIDE  = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic                          started_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic signed [SUM_WIDTH-1:0]   sum_reg [2];
    logic [SCORE_WIDTH-1:0]        hist_reg [SLOTS][2];
    logic [SCORE_WIDTH-1:0]        root0_reg;
    logic [2:0]                    i_reg;
    logic [SCORE_WIDTH-1:0]        best_reg;
    logic                          found_reg;
    logic [2:0]                    best_off_reg;
    logic                          best_pol_reg;
    logic                          applied_drop_reg, pending_drop_reg;
    logic [3:0]                    applied_off0_reg, applied_off1_reg;
    logic [3:0]                    pending_off0_reg, pending_off1_reg;
    logic                          applied_pol_reg, pending_pol_reg;
    logic                          out_valid_reg;
    logic [RES_W-1:0]              out_data_reg;

    logic [SLOT_W-1:0]             slot_cur, slot_adv, prev_idx, idx_sum, idx;
    logic signed [SUM_WIDTH-1:0]   acc, acc_new, sum_sel;
    logic signed [SUM_WIDTH:0]     acc_x;
    logic                          sq_start, sq_done;
    logic [RAD_W-1:0]              sq_rad;
    logic [ROOT_W-1:0]             sq_root;
    logic [WIDE_W-1:0]             root_wide;
    logic [SCORE_WIDTH-1:0]        score_sat;
    logic [SCORE_WIDTH-1:0]        v1, v2, best_a, best_b;
    logic                          hit1, hit2;
    logic [2:0]                    dec_off, off_a, off_b, off_plus;
    logic                          pol_a, pol_b;
    logic                          emit_ok;
    logic [2:0]                    next_off;
    logic                          next_pol;

    tcd_sqrt #(.ROOT_W(ROOT_W)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign slot_cur = started_reg ? slot_reg : (decomb_mode ? SLOT_W'(0) : SLOT_W'(4));
    assign slot_adv = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign prev_idx = (slot_reg == '0) ? SLOT_W'(SLOTS - 1) : slot_reg - 1'b1;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    assign acc   = sum_reg[q_entry.field];
    assign acc_x = {acc[SUM_WIDTH-1], acc}
                 + {{(SUM_WIDTH + 1 - TERM_W){q_entry.term[TERM_W-1]}}, q_entry.term};
    always_comb
    begin
        if (acc_x[SUM_WIDTH] != acc_x[SUM_WIDTH-1])
        begin
            acc_new = acc_x[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            acc_new = acc_x[SUM_WIDTH-1:0];
        end
    end

    assign sq_start = (state_reg == ST_R0_GO) || (state_reg == ST_R1_GO);
    assign sum_sel  = sum_reg[state_reg == ST_R1_GO];
    assign sq_rad   = sum_sel[SUM_WIDTH-1] ? '0 : RAD_W'(unsigned'(sum_sel));

    assign root_wide = WIDE_W'(sq_root);
    assign score_sat = (root_wide > WIDE_W'({SCORE_WIDTH{1'b1}})) ? {SCORE_WIDTH{1'b1}}
                                                                  : root_wide[SCORE_WIDTH-1:0];

    assign idx_sum = slot_reg + SLOT_W'(4) + SLOT_W'(i_reg);
    assign idx     = (idx_sum >= SLOT_W'(SLOTS)) ? idx_sum - SLOT_W'(SLOTS) : idx_sum;
    assign v1      = hist_reg[idx][0];
    assign v2      = hist_reg[idx][1];
    assign dec_off = (i_reg == 3'd0) ? 3'(CYCLE - 1) : i_reg - 1'b1;

    assign hit1   = (v1 > best_reg);
    assign best_a = hit1 ? v1 : best_reg;
    assign off_a  = hit1 ? dec_off : best_off_reg;
    assign pol_a  = hit1 ? 1'b1 : best_pol_reg;
    assign hit2   = (v2 > best_a);
    assign best_b = hit2 ? v2 : best_a;
    assign off_b  = hit2 ? dec_off : off_a;
    assign pol_b  = hit2 ? 1'b0 : pol_a;

    assign emit_ok  = !out_valid_reg || res_ready;
    assign off_plus = (best_off_reg == 3'(CYCLE - 1)) ? 3'd0 : best_off_reg + 1'b1;
    assign next_off = found_reg ? best_off_reg : 3'd0;
    assign next_pol = found_reg ? best_pol_reg : pending_pol_reg;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop && q_entry.last && !lock_enable)
                begin
                    state_next = ST_R0_GO;
                end
            end
            ST_R0_GO:
            begin
                state_next = ST_R0_WAIT;
            end
            ST_R0_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = ST_R1_GO;
                end
            end
            ST_R1_GO:
            begin
                state_next = ST_R1_WAIT;
            end
            ST_R1_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = (slot_adv == '0 || slot_adv == SLOT_W'(CYCLE)) ? ST_DECIDE
                                                                                : ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                if (i_reg == 3'(CYCLE - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            started_reg      <= 1'b0;
            slot_reg         <= '0;
            sum_reg[0]       <= '0;
            sum_reg[1]       <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                hist_reg[s][0] <= '0;
                hist_reg[s][1] <= '0;
            end
            applied_drop_reg <= 1'b1;
            applied_off0_reg <= 4'hF;
            applied_off1_reg <= 4'hF;
            applied_pol_reg  <= 1'b0;
            pending_drop_reg <= 1'b1;
            pending_off0_reg <= 4'hF;
            pending_off1_reg <= 4'hF;
            pending_pol_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                started_reg <= 1'b1;
                if (lock_enable)
                begin
                    if (q_entry.last)
                    begin
                        sum_reg[0] <= '0;
                        sum_reg[1] <= '0;
                        slot_reg   <= (slot_cur == SLOT_W'(SLOTS - 1)) ? '0
                                                                       : slot_cur + 1'b1;
                    end
                    else
                    begin
                        slot_reg <= slot_cur;
                    end
                end
                else
                begin
                    slot_reg               <= slot_cur;
                    sum_reg[q_entry.field] <= acc_new;
                end
            end
            if (state_reg == ST_R1_WAIT && sq_done)
            begin
                hist_reg[prev_idx][0] <= root0_reg;
                hist_reg[prev_idx][1] <= score_sat;
                sum_reg[0]            <= '0;
                sum_reg[1]            <= '0;
                slot_reg              <= slot_adv;
            end
            if (state_reg == ST_EMIT && emit_ok)
            begin
                applied_drop_reg <= pending_drop_reg;
                applied_off0_reg <= pending_off0_reg;
                applied_off1_reg <= pending_off1_reg;
                applied_pol_reg  <= pending_pol_reg;
                pending_drop_reg <= !found_reg;
                pending_off0_reg <= {1'b0, next_off};
                pending_off1_reg <= found_reg ? {1'b0, off_plus} : 4'd1;
                pending_pol_reg  <= next_pol;
                out_valid_reg    <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_R0_WAIT && sq_done)
        begin
            root0_reg <= score_sat;
        end
        if (state_reg == ST_R1_WAIT)
        begin
            i_reg        <= '0;
            best_reg     <= '0;
            found_reg    <= 1'b0;
            best_off_reg <= '0;
            best_pol_reg <= 1'b0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            i_reg        <= i_reg + 1'b1;
            best_reg     <= best_b;
            found_reg    <= found_reg || hit1 || hit2;
            best_off_reg <= off_b;
            best_pol_reg <= pol_b;
        end
        if (state_reg == ST_EMIT && emit_ok)
        begin
            out_data_reg <= {best_reg, next_pol, next_off, !found_reg, pending_pol_reg,
                             pending_off1_reg, pending_off0_reg, pending_drop_reg};
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(SLOTS - 1))
        else $error("slot index left its range");

    a_decide_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (slot_reg == '0 || slot_reg == SLOT_W'(CYCLE)))
        else $error("decision started away from a cadence boundary");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_ok) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("decision did not reach the result register");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("queue drained while a frame end was in progress");

endmodule

@@ test/telecine_cadence_detector_test.sv @@
// Self-checking testbench for telecine_cadence_detector: pixel stream in, cadence decisions out.
// Depends on tcd_pkg and the RTL top level; a cadence predictor checks the decisions, one against a fixed value.
module telecine_cadence_detector_test;
    import tcd_pkg::*;

    localparam int SUM_W        = SUM_W_DEFAULT;
    localparam int SCORE_W      = SCORE_W_DEFAULT;
    localparam int OUT_W        = ((SCORE_W + 22) / 8) * 8;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 600000;
    localparam longint SUM_MAX  = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_MIN  = -SUM_MAX - 1;

    typedef struct packed {
        logic [7:0] cur_above;
        logic [7:0] cur_middle;
        logic [7:0] cur_below;
        logic [7:0] prev_above;
        logic [7:0] prev_middle;
        logic [7:0] prev_below;
        logic       field_select;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        logic               drop_mode;
        logic signed [3:0]  offset_first;
        logic signed [3:0]  offset_second;
        logic               invert_polarity;
        logic               next_drop_mode;
        logic [2:0]         next_offset;
        logic               next_polarity;
        logic [SCORE_W-1:0] win_score;
    } decision_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        pixel_t    pix;
        logic      reg_idx;
        logic      reg_val;
        logic      typed;
        decision_t exp;
    } row_t;

    typedef enum logic [1:0] {PAT_RANDOM, PAT_FLAT, PAT_COMBED, PAT_EXTREME} pattern_t;

    localparam decision_t FIRST_DECISION =
        '{1'b1, 4'hF, 4'hF, 1'b0, 1'b1, 3'd0, 1'b0, {SCORE_W{1'b0}}};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor state.
    int unsigned         slot;
    bit                  started;
    longint              field_sum [2];
    logic [SCORE_W-1:0]  history [SLOTS][2];
    bit                  app_drop;
    int                  app_off [2];
    bit                  app_pol;
    bit                  pend_drop;
    int                  pend_off [2];
    bit                  pend_pol;
    bit                  cfg_lock;
    bit                  cfg_decomb;

    decision_t           due_decisions [$];
    row_t                plan [$];
    row_t                row;
    int                  mismatches;
    int                  n_pixels;
    int                  n_decisions;
    int                  cycle_count;
    int                  in_idle_max;
    int                  out_idle_max;
    bit                  hold_request;

    telecine_cadence_detector i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 clk = ~clk;

    function automatic longint sq(int v);
        return longint'(v) * longint'(v);
    endfunction

    function automatic logic [SCORE_W-1:0] field_root(longint s);
        longint unsigned x;
        longint unsigned r;
        longint unsigned t;
        if (s <= 0)
            return '0;
        x = longint'(s);
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= x)
                r = t;
        end
        if (r > ((64'd1 << SCORE_W) - 1))
            return '1;
        return r[SCORE_W-1:0];
    endfunction

    function automatic bit cadence_step(input pixel_t p, output decision_t d);
        longint             term;
        longint             acc;
        int unsigned        idx;
        logic [SCORE_W-1:0] best;
        int                 best_off;
        bit                 best_pol;
        d = '0;
        best = '0;
        best_off = -1;
        best_pol = 1'b0;
        if (!started)
        begin
            slot = cfg_decomb ? 0 : 4;
            started = 1'b1;
        end
        if (slot >= SLOTS)
            slot = 0;
        if (cfg_lock)
        begin
            if (p.frame_end)
            begin
                field_sum[0] = 0;
                field_sum[1] = 0;
                slot = (slot + 1) % SLOTS;
            end
            return 1'b0;
        end
        term = sq(int'(p.cur_above) + int'(p.cur_below) - 2 * int'(p.cur_middle))
             + sq(int'(p.prev_above) + int'(p.prev_below) - 2 * int'(p.prev_middle))
             - sq(int'(p.cur_above) + int'(p.cur_below) - 2 * int'(p.prev_middle));
        acc = field_sum[p.field_select] + term;
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        if (acc < SUM_MIN)
            acc = SUM_MIN;
        field_sum[p.field_select] = acc;
        if (!p.frame_end)
            return 1'b0;
        idx = (slot + SLOTS - 1) % SLOTS;
        history[idx][0] = field_root(field_sum[0]);
        history[idx][1] = field_root(field_sum[1]);
        field_sum[0] = 0;
        field_sum[1] = 0;
        slot = (slot + 1) % SLOTS;
        if (slot != 0 && slot != CYCLE)
            return 1'b0;
        for (int i = 0; i < CYCLE; i++)
        begin
            idx = (slot + CYCLE - 1 + i) % SLOTS;
            if (history[idx][0] > best)
            begin
                best_off = (i + CYCLE - 1) % CYCLE;
                best_pol = 1'b1;
                best = history[idx][0];
            end
            if (history[idx][1] > best)
            begin
                best_off = (i + CYCLE - 1) % CYCLE;
                best_pol = 1'b0;
                best = history[idx][1];
            end
        end
        app_drop = pend_drop;
        app_off[0] = pend_off[0];
        app_off[1] = pend_off[1];
        app_pol = pend_pol;
        if (best_off < 0)
        begin
            pend_drop = 1'b1;
            pend_off[0] = 0;
            pend_off[1] = 1;
        end
        else
        begin
            pend_drop = 1'b0;
            pend_off[0] = best_off;
            pend_off[1] = (best_off + 1) % CYCLE;
            pend_pol = best_pol;
        end
        d.drop_mode = app_drop;
        d.offset_first = 4'(app_off[0]);
        d.offset_second = 4'(app_off[1]);
        d.invert_polarity = app_pol;
        d.next_drop_mode = pend_drop;
        d.next_offset = 3'(pend_off[0]);
        d.next_polarity = pend_pol;
        d.win_score = best;
        return 1'b1;
    endfunction

    function automatic row_t px(logic [7:0] ca, logic [7:0] cm, logic [7:0] cb,
                                logic [7:0] pa, logic [7:0] pm, logic [7:0] pb,
                                logic fs, logic fe);
        row_t r;
        r = '0;
        r.kind = ROW_PIXEL;
        r.pix = '{ca, cm, cb, pa, pm, pb, fs, fe};
        return r;
    endfunction

    function automatic row_t wr(logic idx, logic val);
        row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic pixel_t make_pixel(pattern_t k);
        pixel_t     p;
        logic [7:0] x;
        logic [7:0] y;
        p = '0;
        x = 8'($urandom_range(0, 255));
        y = 8'($urandom_range(0, 255));
        case (k)
            PAT_FLAT:
            begin
                p.cur_above = x;
                p.cur_middle = x;
                p.cur_below = x;
                p.prev_above = y;
                p.prev_middle = y;
                p.prev_below = y;
            end
            PAT_COMBED:
            begin
                p.cur_above = x;
                p.cur_middle = y;
                p.cur_below = x;
                p.prev_above = x ^ 8'($urandom_range(0, 15));
                p.prev_middle = x ^ 8'($urandom_range(0, 15));
                p.prev_below = x ^ 8'($urandom_range(0, 15));
            end
            PAT_EXTREME:
            begin
                p.cur_above = {8{1'($urandom_range(0, 1))}};
                p.cur_middle = {8{1'($urandom_range(0, 1))}};
                p.cur_below = {8{1'($urandom_range(0, 1))}};
                p.prev_above = {8{1'($urandom_range(0, 1))}};
                p.prev_middle = {8{1'($urandom_range(0, 1))}};
                p.prev_below = {8{1'($urandom_range(0, 1))}};
            end
            default:
            begin
                p.cur_above = x;
                p.cur_middle = y;
                p.cur_below = 8'($urandom_range(0, 255));
                p.prev_above = 8'($urandom_range(0, 255));
                p.prev_middle = 8'($urandom_range(0, 255));
                p.prev_below = 8'($urandom_range(0, 255));
            end
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p, input logic typed, input decision_t exp);
        int        gap;
        decision_t d;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.prev_below, p.prev_middle, p.prev_above,
                         p.cur_below, p.cur_middle, p.cur_above};
        s_axis_tuser <= p.field_select;
        s_axis_tlast <= p.frame_end;
        do @(posedge clk); while (!s_axis_tready);
        n_pixels++;
        if (cadence_step(p, d))
            due_decisions.push_back(typed ? exp : d);
    endtask

    task automatic send_frames(input int n_items);
        int       sent;
        int       frames;
        int       len;
        pattern_t group_kind;
        pattern_t kind;
        pixel_t   p;
        sent = 0;
        while (sent < n_items)
        begin
            group_kind = pattern_t'($urandom_range(0, 3));
            frames = (group_kind == PAT_FLAT) ? 2 * CYCLE : CYCLE;
            repeat (frames)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 30)
                                                   : $urandom_range(1, 5);
                kind = ($urandom_range(0, 9) == 0) ? pattern_t'($urandom_range(0, 3))
                                                   : group_kind;
                for (int j = 0; j < len; j++)
                begin
                    p = make_pixel(kind);
                    p.field_select = 1'($urandom_range(0, 1));
                    p.frame_end = (j == len - 1);
                    send_pixel(p, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (due_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LOCK)
            cfg_lock = val;
        else
            cfg_decomb = val;
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_decisions
        decision_t want;
        decision_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.drop_mode = m_axis_tdata[0];
            got.offset_first = m_axis_tdata[4:1];
            got.offset_second = m_axis_tdata[8:5];
            got.invert_polarity = m_axis_tdata[9];
            got.next_drop_mode = m_axis_tdata[10];
            got.next_offset = m_axis_tdata[13:11];
            got.next_polarity = m_axis_tdata[14];
            got.win_score = m_axis_tdata[15 +: SCORE_W];
            if (due_decisions.size() == 0)
            begin
                $error("decision transaction arrived with none expected");
                mismatches++;
            end
            else
            begin
                want = due_decisions.pop_front();
                n_decisions++;
                compare_field("drop_mode", want.drop_mode, got.drop_mode);
                compare_field("offset_first", 4'(want.offset_first), 4'(got.offset_first));
                compare_field("offset_second", 4'(want.offset_second), 4'(got.offset_second));
                compare_field("invert_polarity", want.invert_polarity, got.invert_polarity);
                compare_field("next_drop_mode", want.next_drop_mode, got.next_drop_mode);
                compare_field("next_offset", want.next_offset, got.next_offset);
                compare_field("next_polarity", want.next_polarity, got.next_polarity);
                compare_field("win_score", want.win_score, got.win_score);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : receiver
        int wait_cycles;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            wait_cycles = $urandom_range(0, out_idle_max);
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        mismatches = 0;
        n_pixels = 0;
        n_decisions = 0;
        hold_request = 1'b0;
        in_idle_max = 8;
        out_idle_max = 8;
        slot = 0;
        started = 1'b0;
        field_sum[0] = 0;
        field_sum[1] = 0;
        foreach (history[i])
        begin
            history[i][0] = '0;
            history[i][1] = '0;
        end
        app_drop = 1'b1;
        app_off[0] = -1;
        app_off[1] = -1;
        app_pol = 1'b0;
        pend_drop = 1'b1;
        pend_off[0] = -1;
        pend_off[1] = -1;
        pend_pol = 1'b0;
        cfg_lock = 1'b0;
        cfg_decomb = 1'b0;

        // Decomb mode is set before the first pixel so that the first slot is zero.
        plan.push_back(wr(REG_LOCK, 1'b0));
        plan.push_back(wr(REG_DECOMB, 1'b1));
        plan.push_back(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        plan.push_back(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        plan.push_back(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        plan.push_back(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        row = px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        row.typed = 1'b1;
        row.exp = FIRST_DECISION;
        plan.push_back(row);
        plan.push_back(px(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
        plan.push_back(px(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        plan.push_back(px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        plan.push_back(px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        plan.push_back(px(8'h12, 8'hF0, 8'h34, 8'hAB, 8'h01, 8'hCD, 1'b1, 1'b1));
        plan.push_back(px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
        // Lock mode: the sums are dropped but the slot keeps moving.
        plan.push_back(wr(REG_LOCK, 1'b1));
        plan.push_back(px(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0));
        plan.push_back(px(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1));
        plan.push_back(px(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 1'b1));
        plan.push_back(px(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1));
        plan.push_back(wr(REG_LOCK, 1'b0));
        // A later decomb write must leave the slot where it is.
        plan.push_back(wr(REG_DECOMB, 1'b0));
        plan.push_back(px(8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h80, 1'b1, 1'b1));
        plan.push_back(px(8'hF0, 8'h0F, 8'hF0, 8'h11, 8'h22, 8'h33, 1'b0, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_pixel(plan[i].pix, plan[i].typed, plan[i].exp);
            end
        end

        send_frames(450);

        wait_idle();
        write_reg(REG_LOCK, 1'b1);
        in_idle_max = 3;
        send_frames(150);

        wait_idle();
        write_reg(REG_LOCK, 1'b0);
        wait_idle();
        write_reg(REG_DECOMB, 1'b1);
        in_idle_max = 0;
        out_idle_max = 0;
        hold_request = 1'b1;
        send_frames(300);

        in_idle_max = 8;
        out_idle_max = 8;
        send_frames(150);
        wait_idle();
        send_frames(150);

        wait_idle();
        $display("Covered %0d pixel transactions and %0d cadence decisions", n_pixels,
                 n_decisions);
        $display("over lock and unlock phases, both decomb settings and a long output stall.");
        if (mismatches == 0 && due_decisions.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
